// ===== rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue core.
// Depends on nothing; every rtl file but deq_ram refers to it by scoped names.

package deq_pkg;

   // Default number of ring slots.
   localparam int CAPACITY_DEFAULT = 16;

   // Widths fixed by the channel payloads.
   localparam int WORD_W = 32;
   localparam int OCC_W  = 5;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                     operation;
      logic signed [WORD_W-1:0]   push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]   pop_value;
      status_type                 status;
      logic [OCC_W-1:0]           occupancy;
   } rsp_type;

   // Outcome of one request as decided by the pointer unit.
   typedef struct packed {
      status_type          status;
      logic [OCC_W-1:0]    occupancy;
      logic                pop_ok;
      logic                wr_en;
      logic                rd_en;
   } decision_type;

endpackage

// ===== rtl/deq_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // The read data holds until the next read is issued.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/deq_ptr.sv =====
// Front pointer, rear pointer and occupancy count of the ring, plus the
// per-request decision logic. Depends on deq_pkg.

module deq_ptr #(
   parameter int CAPACITY = deq_pkg::CAPACITY_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  deq_pkg::op_type               operation,
   output logic [$clog2(CAPACITY)-1:0]   mem_addr,
   output deq_pkg::decision_type         decision
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   logic [PTR_W-1:0] front_ff, front_in;
   logic [PTR_W-1:0] rear_ff, rear_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [PTR_W-1:0] front_next, front_prev, rear_next, rear_prev;
   logic             is_full, ring_empty;

   assign front_next = (front_ff == LAST_SLOT) ? '0 : front_ff + 1'b1;
   assign front_prev = (front_ff == '0) ? LAST_SLOT : front_ff - 1'b1;
   assign rear_next  = (rear_ff == LAST_SLOT) ? '0 : rear_ff + 1'b1;
   assign rear_prev  = (rear_ff == '0) ? LAST_SLOT : rear_ff - 1'b1;
   assign is_full    = (count_ff == FULL_COUNT);
   assign ring_empty = (count_ff == '0);

   always_comb begin
      front_in          = front_ff;
      rear_in           = rear_ff;
      count_in          = count_ff;
      mem_addr          = front_ff;
      decision.status   = deq_pkg::STAT_OK;
      decision.pop_ok   = 1'b0;
      decision.wr_en    = 1'b0;
      decision.rd_en    = 1'b0;
      unique case (operation)
         deq_pkg::OP_PUSH_FRONT: begin
            mem_addr = front_prev;
            if (is_full) begin
               decision.status = deq_pkg::STAT_FULL;
            end else begin
               decision.wr_en = 1'b1;
               front_in       = front_prev;
               count_in       = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_PUSH_REAR: begin
            mem_addr = rear_ff;
            if (is_full) begin
               decision.status = deq_pkg::STAT_FULL;
            end else begin
               decision.wr_en = 1'b1;
               rear_in        = rear_next;
               count_in       = count_ff + 1'b1;
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            mem_addr = front_ff;
            if (ring_empty) begin
               decision.status = deq_pkg::STAT_EMPTY;
            end else begin
               decision.rd_en  = 1'b1;
               decision.pop_ok = 1'b1;
               front_in        = front_next;
               count_in        = count_ff - 1'b1;
            end
         end
         deq_pkg::OP_POP_REAR: begin
            mem_addr = rear_prev;
            if (ring_empty) begin
               decision.status = deq_pkg::STAT_EMPTY;
            end else begin
               decision.rd_en  = 1'b1;
               decision.pop_ok = 1'b1;
               rear_in         = rear_prev;
               count_in        = count_ff - 1'b1;
            end
         end
         default: begin
            mem_addr = front_ff;
         end
      endcase
      // Memory strobes only fire for an accepted request.
      decision.wr_en     = decision.wr_en & accept;
      decision.rd_en     = decision.rd_en & accept;
      decision.occupancy = deq_pkg::OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/double_ended_queue_core.sv =====
// Top level of the double-ended queue core: request/response channels,
// pointer unit and slot memory. Depends on deq_pkg, deq_ptr and deq_ram.

// The core holds up to CAPACITY signed 32-bit words in a ring of memory slots
// and serves four requests: push at the front, push at the rear, pop from the
// front and pop from the rear. Every accepted request produces exactly one
// response transfer carrying the popped word (zero unless a pop succeeded),
// a status (ok, pop from empty, push into full) and the number of stored
// words after the request, reported in 5 bits so that it wraps for a
// capacity above 31. A failed request leaves the queue untouched. One
// request can be accepted every clock cycle while the request side does not
// stall; its response passes through the registered read of the slot memory
// and then the response register. A push writes its slot in the cycle it is
// accepted, so a pop accepted in the very next cycle already reads the new
// word. The slot memory needs no clearing after reset, because a pop only
// reads a slot that an earlier push wrote. The request side stalls only when
// the response register is full, stalled, and the memory stage behind it
// also holds a result.

module double_ended_queue_core #(
   parameter int CAPACITY = deq_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  deq_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output deq_pkg::rsp_type  rsp_payload
);

   localparam int ADDR_W = $clog2(CAPACITY);

   logic                    accept;
   logic                    advance;
   logic [ADDR_W-1:0]       mem_addr;
   deq_pkg::decision_type   decision;
   logic [deq_pkg::WORD_W-1:0] rd_data;

   // The memory stage holds the decision of the request whose read is in
   // flight; the response register holds the finished transfer.
   logic                    s1_valid_ff, s1_valid_in;
   deq_pkg::decision_type   s1_info_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type        rsp_payload_ff, rsp_payload_in;

   // The memory stage moves on whenever the response register is free or is
   // being emptied in this cycle.
   assign advance   = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   deq_ptr #(
      .CAPACITY (CAPACITY)
   ) u_ptr (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_payload.operation),
      .mem_addr  (mem_addr),
      .decision  (decision)
   );

   // A read is only issued together with an accepted request, which in turn
   // requires the memory stage to drain, so the read data stays put while
   // the memory stage waits.
   deq_ram #(
      .WIDTH (deq_pkg::WORD_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (decision.wr_en),
      .wr_addr (mem_addr),
      .wr_data (req_payload.push_value),
      .rd_en   (decision.rd_en),
      .rd_addr (mem_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in              = accept | (s1_valid_ff & ~advance);
      rsp_valid_in             = advance | (rsp_valid_ff & rsp_stall);
      rsp_payload_in.pop_value = s1_info_ff.pop_ok ? rd_data : '0;
      rsp_payload_in.status    = s1_info_ff.status;
      rsp_payload_in.occupancy = s1_info_ff.occupancy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_info_ff <= decision;
      end
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
